// ===== rtl/jts_pkg.sv =====
// jts_pkg: beat types, command codes and character tables for the json token serializer
`default_nettype none

package jts_pkg;

    localparam logic [3:0] CMD_OBJ_OPEN  = 4'd0;
    localparam logic [3:0] CMD_OBJ_CLOSE = 4'd1;
    localparam logic [3:0] CMD_ARR_OPEN  = 4'd2;
    localparam logic [3:0] CMD_ARR_CLOSE = 4'd3;
    localparam logic [3:0] CMD_KEY_OPEN  = 4'd4;
    localparam logic [3:0] CMD_STR_OPEN  = 4'd5;
    localparam logic [3:0] CMD_STR_BYTE  = 4'd6;
    localparam logic [3:0] CMD_KEY_CLOSE = 4'd7;
    localparam logic [3:0] CMD_STR_CLOSE = 4'd8;
    localparam logic [3:0] CMD_INT       = 4'd9;
    localparam logic [3:0] CMD_UINT      = 4'd10;
    localparam logic [3:0] CMD_BOOL      = 4'd11;
    localparam logic [3:0] CMD_NULL      = 4'd12;
    localparam logic [3:0] CMD_RESET     = 4'd13;

    // decimal conversion: 32 binary bits into 10 bcd digits
    localparam int BIN_W   = 32;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = 4 * DIGITS;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] operand;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_beat;

    function automatic logic [7:0] f_hex(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'h0, v};
        end
        return 8'h37 + {4'h0, v};
    endfunction

    // number of bytes a string byte turns into
    function automatic logic [2:0] f_esc_len(input logic [7:0] ch);
        case (ch)
            8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0C: return 3'd2;
            default: begin
                if (ch < 8'h20) begin
                    return 3'd6;
                end
                return 3'd1;
            end
        endcase
    endfunction

    function automatic logic [7:0] f_esc_byte(input logic [7:0] ch, input logic [2:0] idx);
        logic [7:0] sec;
        sec = 8'h00;
        case (ch)
            8'h22: sec = "\"";
            8'h5C: sec = "\\";
            8'h0A: sec = "n";
            8'h0D: sec = "r";
            8'h09: sec = "t";
            8'h08: sec = "b";
            8'h0C: sec = "f";
            default: sec = 8'h00;
        endcase
        if (sec != 8'h00) begin
            return (idx == 3'd0) ? 8'h5C : sec;
        end
        if (ch >= 8'h20) begin
            return ch;
        end
        case (idx)
            3'd0:    return 8'h5C;
            3'd1:    return "u";
            3'd2:    return "0";
            3'd3:    return "0";
            3'd4:    return f_hex(ch[7:4]);
            default: return f_hex(ch[3:0]);
        endcase
    endfunction

    // byte count of the text part of every non-numeric token
    function automatic logic [2:0] f_body_len(input logic [3:0] cmd, input logic [7:0] ch,
                                              input logic bval);
        case (cmd)
            CMD_STR_BYTE:  return f_esc_len(ch);
            CMD_KEY_CLOSE: return 3'd2;
            CMD_BOOL:      return bval ? 3'd4 : 3'd5;
            CMD_NULL:      return 3'd4;
            default:       return 3'd1;
        endcase
    endfunction

    function automatic logic [7:0] f_body_byte(input logic [3:0] cmd, input logic [7:0] ch,
                                               input logic bval, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (cmd)
            CMD_OBJ_OPEN:  b = "{";
            CMD_OBJ_CLOSE: b = "}";
            CMD_ARR_OPEN:  b = "[";
            CMD_ARR_CLOSE: b = "]";
            CMD_STR_BYTE:  b = f_esc_byte(ch, idx);
            CMD_KEY_CLOSE: b = (idx == 3'd0) ? "\"" : ":";
            CMD_BOOL: begin
                if (bval) begin
                    case (idx)
                        3'd0:    b = "t";
                        3'd1:    b = "r";
                        3'd2:    b = "u";
                        default: b = "e";
                    endcase
                end else begin
                    case (idx)
                        3'd0:    b = "f";
                        3'd1:    b = "a";
                        3'd2:    b = "l";
                        3'd3:    b = "s";
                        default: b = "e";
                    endcase
                end
            end
            CMD_NULL: begin
                case (idx)
                    3'd0:    b = "n";
                    3'd1:    b = "u";
                    default: b = "l";
                endcase
            end
            default: b = "\"";
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/json_token_serializer.sv =====
// json_token_serializer: turns json tokens into escaped json text, one byte per output beat
//
// input channel: one beat per token (cmd, operand), taken only while the block is idle.
// output channel: one beat per text byte, last marks the token's final byte.
// a small sequencer walks each token's bytes into a single output register, so one
// byte of a token leaves per cycle while the sequencer emits and the receiver keeps ready high.
// punctuation, words and string bytes: the accepted beat moves the sequencer to its emit
// state, which writes the bytes into the output register, one per cycle while ready is high;
// the block is ready again once the last byte enters the output register.
// integers run through a single shift-and-add-3 unit, one binary bit per cycle
// for all 32 bits, then drop leading zero digits one per cycle (up to 9), then emit.
// tokens that give no text (reset command, unused codes) leave the block idle and ready.
// a stalled receiver holds the output register; the sequencer waits behind it.
// reset empties the output register, returns to idle and clears the pending comma.
`default_nettype none

module json_token_serializer (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  jts_pkg::t_in_beat      i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output jts_pkg::t_out_beat     o_out_data
);
    import jts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_TRIM = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic              r_comma_pending, n_comma_pending;
    logic              r_ovalid, n_ovalid;
    t_out_beat         r_obeat, n_obeat;

    logic [3:0]        r_cmd, n_cmd;
    logic [7:0]        r_ch, n_ch;
    logic              r_bval, n_bval;
    logic              r_comma, n_comma;
    logic              r_neg, n_neg;
    logic              r_dec, n_dec;
    logic [2:0]        r_idx, n_idx;
    logic [BIN_W-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [4:0]        r_cnt, n_cnt;
    logic [3:0]        r_ndig, n_ndig;

    logic              w_accept;
    logic              w_room;
    logic [BCD_W-1:0]  w_adj;
    logic [2:0]        w_len;
    logic              w_body_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_room      = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_obeat;

    assign w_len       = f_body_len(r_cmd, r_ch, r_bval);
    assign w_body_last = (r_idx == w_len - 3'd1);

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_state         = r_state;
        n_comma_pending = r_comma_pending;
        n_ovalid        = r_ovalid && !i_out_ready;
        n_obeat         = r_obeat;
        n_cmd           = r_cmd;
        n_ch            = r_ch;
        n_bval          = r_bval;
        n_comma         = r_comma;
        n_neg           = r_neg;
        n_dec           = r_dec;
        n_idx           = r_idx;
        n_bin           = r_bin;
        n_bcd           = r_bcd;
        n_cnt           = r_cnt;
        n_ndig          = r_ndig;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_in_data.cmd;
                    n_ch    = i_in_data.operand[7:0];
                    n_bval  = i_in_data.operand[0];
                    n_idx   = 3'd0;
                    n_neg   = 1'b0;
                    n_dec   = 1'b0;
                    n_comma = 1'b0;
                    n_bcd   = '0;
                    n_cnt   = 5'(BIN_W - 1);
                    n_ndig  = 4'(DIGITS);
                    n_bin   = i_in_data.operand;
                    unique case (i_in_data.cmd) inside
                        CMD_OBJ_OPEN, CMD_ARR_OPEN, CMD_KEY_OPEN, CMD_STR_OPEN: begin
                            n_comma         = r_comma_pending;
                            n_comma_pending = 1'b0;
                            n_state         = S_EMIT;
                        end
                        CMD_KEY_CLOSE: begin
                            n_comma_pending = 1'b0;
                            n_state         = S_EMIT;
                        end
                        CMD_OBJ_CLOSE, CMD_ARR_CLOSE, CMD_STR_CLOSE: begin
                            n_comma_pending = 1'b1;
                            n_state         = S_EMIT;
                        end
                        CMD_STR_BYTE: begin
                            n_state = S_EMIT;
                        end
                        CMD_BOOL, CMD_NULL: begin
                            n_comma         = r_comma_pending;
                            n_comma_pending = 1'b1;
                            n_state         = S_EMIT;
                        end
                        CMD_INT, CMD_UINT: begin
                            n_comma         = r_comma_pending;
                            n_comma_pending = 1'b1;
                            n_dec           = 1'b1;
                            if (i_in_data.cmd == CMD_INT && i_in_data.operand[31]) begin
                                n_neg = 1'b1;
                                n_bin = ~i_in_data.operand + 32'd1;
                            end
                            n_state = S_CONV;
                        end
                        CMD_RESET: begin
                            n_comma_pending = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[BIN_W-1]};
                n_bin = {r_bin[BIN_W-2:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                // drop leading zero digits, keep at least one
                if (r_bcd[BCD_W-1 -: 4] == 4'd0 && r_ndig > 4'd1) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - 4'd1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_room) begin
                    n_ovalid = 1'b1;
                    if (r_comma) begin
                        n_obeat = '{out_byte: ",", last: 1'b0};
                        n_comma = 1'b0;
                    end else if (r_neg) begin
                        n_obeat = '{out_byte: "-", last: 1'b0};
                        n_neg   = 1'b0;
                    end else if (r_dec) begin
                        n_obeat = '{out_byte: 8'h30 + {4'h0, r_bcd[BCD_W-1 -: 4]},
                                    last: (r_ndig == 4'd1)};
                        n_bcd   = {r_bcd[BCD_W-5:0], 4'd0};
                        n_ndig  = r_ndig - 4'd1;
                        if (r_ndig == 4'd1) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_obeat = '{out_byte: f_body_byte(r_cmd, r_ch, r_bval, r_idx),
                                    last: w_body_last};
                        n_idx   = r_idx + 3'd1;
                        if (w_body_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_comma_pending <= 1'b0;
            r_ovalid        <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_comma_pending <= n_comma_pending;
            r_ovalid        <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obeat <= n_obeat;
        r_cmd   <= n_cmd;
        r_ch    <= n_ch;
        r_bval  <= n_bval;
        r_comma <= n_comma;
        r_neg   <= n_neg;
        r_dec   <= n_dec;
        r_idx   <= n_idx;
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_ndig  <= n_ndig;
    end

`ifndef NO_ASSERTIONS
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_room && !r_comma && !r_neg && n_obeat.last)
        |=> (r_state == S_IDLE))
        else $error("last beat did not end the token");

    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_cnt == 5'd0) |=> (r_state == S_TRIM))
        else $error("conversion did not finish after 32 steps");

    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_dec) |-> (r_ndig != 4'd0))
        else $error("decimal emit ran out of digits");

    a_reset_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.cmd == CMD_RESET) |=> (!r_comma_pending && o_in_ready))
        else $error("reset command left comma pending or busy");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> (r_ovalid && $stable(r_obeat)))
        else $error("output register changed while stalled");
`endif

endmodule

`default_nettype wire
